// ===== rtl/wpd_pkg.sv =====
// Package for the whitened packet deframer: types, register codes, PN9 table and CRC helper.
package wpd_pkg;

  localparam int unsigned SyncBitsDefault = 32;
  localparam int unsigned WhitenTableDepth = 256;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 32;

  localparam logic [31:0] SyncWordRst = 32'hd391_d391;
  localparam logic [15:0] CrcPolyRst = 16'h8005;
  localparam logic [15:0] CrcInitRst = 16'hffff;
  localparam logic        WhitenEnRst = 1'b1;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SYNC_WORD = 2'd0,
    CFG_CRC_POLY  = 2'd1,
    CFG_CRC_INIT  = 2'd2,
    CFG_WHITEN_EN = 2'd3
  } cfg_addr_e;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CRC     = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic       kind_res;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       last;
  } result_t;

  localparam logic [7:0] PN9_ROM [WhitenTableDepth] = '{
    8'hff, 8'he1, 8'h1d, 8'h9a, 8'hed, 8'h85, 8'h33, 8'h24,
    8'hea, 8'h7a, 8'hd2, 8'h39, 8'h70, 8'h97, 8'h57, 8'h0a,
    8'h54, 8'h7d, 8'h2d, 8'hd8, 8'h6d, 8'h0d, 8'hba, 8'h8f,
    8'h67, 8'h59, 8'hc7, 8'ha2, 8'hbf, 8'h34, 8'hca, 8'h18,
    8'h30, 8'h53, 8'h93, 8'hdf, 8'h92, 8'hec, 8'ha7, 8'h15,
    8'h8a, 8'hdc, 8'hf4, 8'h86, 8'h55, 8'h4e, 8'h18, 8'h21,
    8'h40, 8'hc4, 8'hc4, 8'hd5, 8'hc6, 8'h91, 8'h8a, 8'hcd,
    8'he7, 8'hd1, 8'h4e, 8'h09, 8'h32, 8'h17, 8'hdf, 8'h83,
    8'hff, 8'hf0, 8'h0e, 8'hcd, 8'hf6, 8'hc2, 8'h19, 8'h12,
    8'h75, 8'h3d, 8'he9, 8'h1c, 8'hb8, 8'hcb, 8'h2b, 8'h05,
    8'haa, 8'hbe, 8'h16, 8'hec, 8'hb6, 8'h06, 8'hdd, 8'hc7,
    8'hb3, 8'hac, 8'h63, 8'hd1, 8'h5f, 8'h1a, 8'h65, 8'h0c,
    8'h98, 8'ha9, 8'hc9, 8'h6f, 8'h49, 8'hf6, 8'hd3, 8'h0a,
    8'h45, 8'h6e, 8'h7a, 8'hc3, 8'h2a, 8'h27, 8'h8c, 8'h10,
    8'h20, 8'h62, 8'he2, 8'h6a, 8'he3, 8'h48, 8'hc5, 8'he6,
    8'hf3, 8'h68, 8'ha7, 8'h04, 8'h99, 8'h8b, 8'hef, 8'hc1,
    8'h7f, 8'h78, 8'h87, 8'h66, 8'h7b, 8'he1, 8'h0c, 8'h89,
    8'hba, 8'h9e, 8'h74, 8'h0e, 8'hdc, 8'he5, 8'h95, 8'h02,
    8'h55, 8'h5f, 8'h0b, 8'h76, 8'h5b, 8'h83, 8'hee, 8'he3,
    8'h59, 8'hd6, 8'hb1, 8'he8, 8'h2f, 8'h8d, 8'h32, 8'h06,
    8'hcc, 8'hd4, 8'he4, 8'hb7, 8'h24, 8'hfb, 8'h69, 8'h85,
    8'h22, 8'h37, 8'hbd, 8'h61, 8'h95, 8'h13, 8'h46, 8'h08,
    8'h10, 8'h31, 8'h71, 8'hb5, 8'h71, 8'ha4, 8'h62, 8'hf3,
    8'h79, 8'hb4, 8'h53, 8'h82, 8'hcc, 8'hc5, 8'hf7, 8'he0,
    8'h3f, 8'hbc, 8'h43, 8'hb3, 8'hbd, 8'h70, 8'h86, 8'h44,
    8'h5d, 8'h4f, 8'h3a, 8'h07, 8'hee, 8'hf2, 8'h4a, 8'h81,
    8'haa, 8'haf, 8'h05, 8'hbb, 8'had, 8'h41, 8'hf7, 8'hf1,
    8'h2c, 8'heb, 8'h58, 8'hf4, 8'h97, 8'h46, 8'h19, 8'h03,
    8'h66, 8'h6a, 8'hf2, 8'h5b, 8'h92, 8'hfd, 8'hb4, 8'h42,
    8'h91, 8'h9b, 8'hde, 8'hb0, 8'hca, 8'h09, 8'h23, 8'h04,
    8'h88, 8'h98, 8'hb8, 8'hda, 8'h38, 8'h52, 8'hb1, 8'hf9,
    8'h3c, 8'hda, 8'h29, 8'h41, 8'he6, 8'he2, 8'h7b, 8'hf0
  };

  // MSB-first CRC16 over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ data[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
    end
    return crc;
  endfunction

endpackage

// ===== rtl/whitened_packet_deframer_crc16_unit.sv =====
// Top level: sync hunt, PN9 de-whitening and CRC16 check of framed bit stream.
//
// Input stream (s_axis_*): one transaction per received symbol. tuser = 1 marks the end
// of a row, tuser = 0 carries a data bit in tdata[0]. After the sync word is found the
// block reads a length byte, that many whitened payload bytes and a big-endian CRC16.
// Output stream (m_axis_*): one transaction per payload byte (tuser = 0) and one
// status transaction per frame (tuser = 1, tlast = 1): ok, CRC mismatch or truncated.
// Throughput: one input transaction per clock while s_axis_tready is high. A result
// appears on m_axis in the cycle after the input transaction that completes it; the
// frame state and output register are the only stages; CRC byte update is combinational.
// When the receiver stalls, the output register holds its result and s_axis_tready
// drops only while that register is full and not being taken.
// Reset clears the frame state to sync hunting with an empty window, loads the register
// defaults and empties the output register. Config writes take effect on the next bit.
module whitened_packet_deframer_crc16_unit #(
  parameter int unsigned SYNC_BITS = wpd_pkg::SyncBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [0] bit_req
  input  logic                          s_axis_tuser,   // [0] kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] data_byte, [15:8] byte_index, [23:16] frame_length, [25:24] status
  output logic [wpd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,   // [0] kind_res
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [wpd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [wpd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wpd_pkg::*;

  localparam int unsigned FillW = $clog2(SYNC_BITS + 1);

  logic [31:0]          sync_word_q;
  logic [15:0]          crc_poly_q, crc_init_q;
  logic                 whiten_en_q;

  logic [SYNC_BITS-1:0] sync_shift_q, sync_shift_d;
  logic [FillW-1:0]     sync_fill_q, sync_fill_d;
  phase_e               phase_q, phase_d;
  logic [2:0]           bit_cnt_q, bit_cnt_d;
  logic [7:0]           byte_asm_q, byte_asm_d;
  logic [7:0]           pay_len_q, pay_len_d;
  logic [7:0]           byte_cnt_q, byte_cnt_d;
  logic [15:0]          crc_q, crc_d;
  logic [15:0]          rx_crc_q, rx_crc_d;

  logic                 out_valid_q, out_valid_d;
  result_t              out_q;
  result_t              res;
  logic                 res_valid;

  logic                 accept;
  logic                 in_bit;
  logic [7:0]           asm_nxt;
  logic [7:0]           pay_byte;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_bit        = s_axis_tdata[0];
  assign asm_nxt       = {byte_asm_q[6:0], in_bit};
  assign pay_byte      = whiten_en_q ? (asm_nxt ^ PN9_ROM[byte_cnt_q]) : asm_nxt;

  always_comb begin
    sync_shift_d = sync_shift_q;
    sync_fill_d  = sync_fill_q;
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    byte_asm_d   = byte_asm_q;
    pay_len_d    = pay_len_q;
    byte_cnt_d   = byte_cnt_q;
    crc_d        = crc_q;
    rx_crc_d     = rx_crc_q;
    res_valid    = 1'b0;
    res          = '0;

    if (s_axis_tuser) begin
      if (phase_q == PH_LEN || phase_q == PH_PAYLOAD || phase_q == PH_CRC) begin
        res_valid        = 1'b1;
        res.kind_res     = 1'b1;
        res.frame_length = (phase_q == PH_LEN) ? 8'd0 : pay_len_q;
        res.status       = ST_TRUNCATED;
        res.last         = 1'b1;
      end
      phase_d      = PH_HUNT;
      sync_shift_d = '0;
      sync_fill_d  = '0;
      bit_cnt_d    = '0;
      byte_asm_d   = '0;
      byte_cnt_d   = '0;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          sync_shift_d = {sync_shift_q[SYNC_BITS-2:0], in_bit};
          if (sync_fill_q < FillW'(SYNC_BITS)) sync_fill_d = sync_fill_q + 1'b1;
          if (sync_fill_q >= FillW'(SYNC_BITS - 1) &&
              sync_shift_d == sync_word_q[SYNC_BITS-1:0]) begin
            phase_d    = PH_LEN;
            bit_cnt_d  = '0;
            byte_asm_d = '0;
            byte_cnt_d = '0;
            pay_len_d  = '0;
            crc_d      = crc_init_q;
            rx_crc_d   = '0;
          end
        end
        PH_CRC: begin
          rx_crc_d  = {rx_crc_q[14:0], in_bit};
          bit_cnt_d = bit_cnt_q + 1'b1;
          if (bit_cnt_q == 3'd7) begin
            byte_cnt_d = byte_cnt_q + 1'b1;
            if (byte_cnt_q != 8'd0) begin
              phase_d          = PH_DONE;
              res_valid        = 1'b1;
              res.kind_res     = 1'b1;
              res.frame_length = pay_len_q;
              res.status       = (rx_crc_d == crc_q) ? ST_OK : ST_CRC_ERR;
              res.last         = 1'b1;
            end
          end
        end
        PH_LEN, PH_PAYLOAD: begin
          byte_asm_d = asm_nxt;
          bit_cnt_d  = bit_cnt_q + 1'b1;
          if (bit_cnt_q == 3'd7) begin
            byte_asm_d = '0;
            if (phase_q == PH_LEN) begin
              pay_len_d  = asm_nxt;
              crc_d      = crc16_byte(crc_q, asm_nxt, crc_poly_q);
              byte_cnt_d = '0;
              phase_d    = (asm_nxt == 8'd0) ? PH_CRC : PH_PAYLOAD;
            end else begin
              crc_d            = crc16_byte(crc_q, pay_byte, crc_poly_q);
              res_valid        = 1'b1;
              res.data_byte    = pay_byte;
              res.byte_index   = byte_cnt_q;
              res.frame_length = pay_len_q;
              byte_cnt_d       = byte_cnt_q + 1'b1;
              if (byte_cnt_d >= pay_len_q) begin
                phase_d    = PH_CRC;
                byte_cnt_d = '0;
                rx_crc_d   = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SyncWordRst;
      crc_poly_q  <= CrcPolyRst;
      crc_init_q  <= CrcInitRst;
      whiten_en_q <= WhitenEnRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SYNC_WORD: sync_word_q <= cfg_data_i[31:0];
        CFG_CRC_POLY:  crc_poly_q  <= cfg_data_i[15:0];
        CFG_CRC_INIT:  crc_init_q  <= cfg_data_i[15:0];
        CFG_WHITEN_EN: whiten_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_shift_q <= '0;
      sync_fill_q  <= '0;
      phase_q      <= PH_HUNT;
      bit_cnt_q    <= '0;
      byte_asm_q   <= '0;
      pay_len_q    <= '0;
      byte_cnt_q   <= '0;
      crc_q        <= CrcInitRst;
      rx_crc_q     <= '0;
    end else if (accept) begin
      sync_shift_q <= sync_shift_d;
      sync_fill_q  <= sync_fill_d;
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      byte_asm_q   <= byte_asm_d;
      pay_len_q    <= pay_len_d;
      byte_cnt_q   <= byte_cnt_d;
      crc_q        <= crc_d;
      rx_crc_q     <= rx_crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.frame_length,
                          out_q.byte_index, out_q.data_byte};
  assign m_axis_tuser  = out_q.kind_res;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== rtl/wpd_checker.sv =====
// Port-level checker for the deframer and its bind to the top level.
module wpd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [wpd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tlast
);
  import wpd_pkg::*;

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tlast == m_axis_tuser)
    else $error("tlast does not match a status transaction");

  a_byte_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[25:24] == ST_OK)
    else $error("payload byte carries a status");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[25:24] != 2'd3)
    else $error("malformed status transaction");

  // a new result only follows an accepted input transaction
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) |->
      $past(s_axis_tvalid && s_axis_tready))
    else $error("result without input transaction");

endmodule

bind whitened_packet_deframer_crc16_unit wpd_checker u_wpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/whitened_packet_deframer_crc16_unit_tb.sv =====
// Self-checking bench for the whitened packet deframer: framed bit rows in, bytes and status out.
`timescale 1ns / 100ps

module whitened_packet_deframer_crc16_unit_tb;
  import wpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    logic       with_sync;
    logic [7:0] len;
    fill_e      fill;
    logic       bad_crc;
    int         cut;
    logic       typed;
    status_e    want;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  whitened_packet_deframer_crc16_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0] pn9_table [256] = '{
    8'hff, 8'he1, 8'h1d, 8'h9a, 8'hed, 8'h85, 8'h33, 8'h24,
    8'hea, 8'h7a, 8'hd2, 8'h39, 8'h70, 8'h97, 8'h57, 8'h0a,
    8'h54, 8'h7d, 8'h2d, 8'hd8, 8'h6d, 8'h0d, 8'hba, 8'h8f,
    8'h67, 8'h59, 8'hc7, 8'ha2, 8'hbf, 8'h34, 8'hca, 8'h18,
    8'h30, 8'h53, 8'h93, 8'hdf, 8'h92, 8'hec, 8'ha7, 8'h15,
    8'h8a, 8'hdc, 8'hf4, 8'h86, 8'h55, 8'h4e, 8'h18, 8'h21,
    8'h40, 8'hc4, 8'hc4, 8'hd5, 8'hc6, 8'h91, 8'h8a, 8'hcd,
    8'he7, 8'hd1, 8'h4e, 8'h09, 8'h32, 8'h17, 8'hdf, 8'h83,
    8'hff, 8'hf0, 8'h0e, 8'hcd, 8'hf6, 8'hc2, 8'h19, 8'h12,
    8'h75, 8'h3d, 8'he9, 8'h1c, 8'hb8, 8'hcb, 8'h2b, 8'h05,
    8'haa, 8'hbe, 8'h16, 8'hec, 8'hb6, 8'h06, 8'hdd, 8'hc7,
    8'hb3, 8'hac, 8'h63, 8'hd1, 8'h5f, 8'h1a, 8'h65, 8'h0c,
    8'h98, 8'ha9, 8'hc9, 8'h6f, 8'h49, 8'hf6, 8'hd3, 8'h0a,
    8'h45, 8'h6e, 8'h7a, 8'hc3, 8'h2a, 8'h27, 8'h8c, 8'h10,
    8'h20, 8'h62, 8'he2, 8'h6a, 8'he3, 8'h48, 8'hc5, 8'he6,
    8'hf3, 8'h68, 8'ha7, 8'h04, 8'h99, 8'h8b, 8'hef, 8'hc1,
    8'h7f, 8'h78, 8'h87, 8'h66, 8'h7b, 8'he1, 8'h0c, 8'h89,
    8'hba, 8'h9e, 8'h74, 8'h0e, 8'hdc, 8'he5, 8'h95, 8'h02,
    8'h55, 8'h5f, 8'h0b, 8'h76, 8'h5b, 8'h83, 8'hee, 8'he3,
    8'h59, 8'hd6, 8'hb1, 8'he8, 8'h2f, 8'h8d, 8'h32, 8'h06,
    8'hcc, 8'hd4, 8'he4, 8'hb7, 8'h24, 8'hfb, 8'h69, 8'h85,
    8'h22, 8'h37, 8'hbd, 8'h61, 8'h95, 8'h13, 8'h46, 8'h08,
    8'h10, 8'h31, 8'h71, 8'hb5, 8'h71, 8'ha4, 8'h62, 8'hf3,
    8'h79, 8'hb4, 8'h53, 8'h82, 8'hcc, 8'hc5, 8'hf7, 8'he0,
    8'h3f, 8'hbc, 8'h43, 8'hb3, 8'hbd, 8'h70, 8'h86, 8'h44,
    8'h5d, 8'h4f, 8'h3a, 8'h07, 8'hee, 8'hf2, 8'h4a, 8'h81,
    8'haa, 8'haf, 8'h05, 8'hbb, 8'had, 8'h41, 8'hf7, 8'hf1,
    8'h2c, 8'heb, 8'h58, 8'hf4, 8'h97, 8'h46, 8'h19, 8'h03,
    8'h66, 8'h6a, 8'hf2, 8'h5b, 8'h92, 8'hfd, 8'hb4, 8'h42,
    8'h91, 8'h9b, 8'hde, 8'hb0, 8'hca, 8'h09, 8'h23, 8'h04,
    8'h88, 8'h98, 8'hb8, 8'hda, 8'h38, 8'h52, 8'hb1, 8'hf9,
    8'h3c, 8'hda, 8'h29, 8'h41, 8'he6, 8'he2, 8'h7b, 8'hf0
  };

  frame_row_t directed_rows [11] = '{
    '{1'b0, 8'd0,   FILL_RANDOM, 1'b0, -1, 1'b0, ST_OK},        // partial window, then row end
    '{1'b1, 8'd0,   FILL_RANDOM, 1'b0, -1, 1'b1, ST_OK},
    '{1'b1, 8'd0,   FILL_RANDOM, 1'b1, -1, 1'b1, ST_CRC_ERR},
    '{1'b1, 8'd3,   FILL_ZERO,   1'b0, -1, 1'b1, ST_OK},
    '{1'b1, 8'd4,   FILL_ONES,   1'b1, -1, 1'b1, ST_CRC_ERR},
    '{1'b1, 8'd2,   FILL_RANDOM, 1'b0,  0, 1'b1, ST_TRUNCATED}, // row end right after sync
    '{1'b1, 8'd2,   FILL_RANDOM, 1'b0,  4, 1'b1, ST_TRUNCATED}, // inside length byte
    '{1'b1, 8'd255, FILL_RANDOM, 1'b0, 24, 1'b1, ST_TRUNCATED},
    '{1'b1, 8'd2,   FILL_RANDOM, 1'b0, 29, 1'b1, ST_TRUNCATED}, // inside CRC
    '{1'b1, 8'd1,   FILL_RANDOM, 1'b0, -1, 1'b0, ST_OK},
    '{1'b1, 8'd20,  FILL_RANDOM, 1'b0, -1, 1'b1, ST_OK}
  };

  // deframer shadow: register copies and frame state
  logic [31:0] sync_cfg = 32'hd391_d391;
  logic [15:0] poly_cfg = 16'h8005;
  logic [15:0] crc_init_cfg = 16'hffff;
  logic        whiten_cfg = 1'b1;
  logic [31:0] sync_window = '0;
  int          window_fill = 0;
  phase_e      phase_q = PH_HUNT;
  logic [2:0]  bit_pos = '0;
  logic [7:0]  shift_byte = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  byte_pos = '0;
  logic [15:0] crc_acc = 16'hffff;
  logic [15:0] crc_rx = '0;

  result_t     pending_results [$];
  result_t     head_result;
  logic        typed_valid = 1'b0;
  status_e     typed_status = ST_OK;

  logic        row_bits [$];
  int          frame_start;
  int unsigned sent_items = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int          gap_pct = 11;
  int          stall_pct = 11;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ poly;
    end
    return c;
  endfunction

  function automatic void deframe_symbol(input logic kind, input logic bitv);
    result_t    r;
    logic       got;
    logic [7:0] b;
    r = '0;
    got = 1'b0;
    if (kind) begin
      if (phase_q == PH_LEN || phase_q == PH_PAYLOAD || phase_q == PH_CRC) begin
        r.kind_res = 1'b1;
        r.frame_length = (phase_q == PH_LEN) ? 8'd0 : frame_len;
        r.status = ST_TRUNCATED;
        r.last = 1'b1;
        got = 1'b1;
      end
      phase_q = PH_HUNT;
      sync_window = '0;
      window_fill = 0;
      bit_pos = '0;
      shift_byte = '0;
      byte_pos = '0;
    end else if (phase_q == PH_HUNT) begin
      sync_window = {sync_window[30:0], bitv};
      if (window_fill < 32) window_fill++;
      if (window_fill >= 32 && sync_window == sync_cfg) begin
        phase_q = PH_LEN;
        bit_pos = '0;
        shift_byte = '0;
        byte_pos = '0;
        frame_len = '0;
        crc_acc = crc_init_cfg;
        crc_rx = '0;
      end
    end else if (phase_q == PH_CRC) begin
      crc_rx = {crc_rx[14:0], bitv};
      bit_pos = bit_pos + 3'd1;
      if (bit_pos == 3'd0) begin
        byte_pos = byte_pos + 8'd1;
        if (byte_pos >= 8'd2) begin
          phase_q = PH_DONE;
          r.kind_res = 1'b1;
          r.frame_length = frame_len;
          r.status = (crc_rx == crc_acc) ? ST_OK : ST_CRC_ERR;
          r.last = 1'b1;
          got = 1'b1;
        end
      end
    end else if (phase_q != PH_DONE) begin
      shift_byte = {shift_byte[6:0], bitv};
      bit_pos = bit_pos + 3'd1;
      if (bit_pos == 3'd0) begin
        b = shift_byte;
        shift_byte = '0;
        if (phase_q == PH_LEN) begin
          frame_len = b;
          crc_acc = crc16_step(crc_acc, b, poly_cfg);
          byte_pos = '0;
          phase_q = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end else begin
          if (whiten_cfg) b = b ^ pn9_table[byte_pos];
          crc_acc = crc16_step(crc_acc, b, poly_cfg);
          r.data_byte = b;
          r.byte_index = byte_pos;
          r.frame_length = frame_len;
          got = 1'b1;
          byte_pos = byte_pos + 8'd1;
          if (byte_pos >= frame_len) begin
            phase_q = PH_CRC;
            byte_pos = '0;
            crc_rx = '0;
          end
        end
      end
    end
    if (got) begin
      if (r.kind_res && typed_valid) r.status = typed_status;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void push_bits(input logic [31:0] v, input int w);
    for (int i = w - 1; i >= 0; i--) row_bits.push_back(v[i]);
  endfunction

  // preamble, sync, length, whitened payload and CRC, MSB first
  function automatic void build_frame(input logic with_sync, input logic [7:0] len,
                                      input fill_e fill, input logic bad_crc);
    logic [15:0] crc;
    logic [7:0]  plain;
    int          pre;
    row_bits.delete();
    pre = with_sync ? $urandom_range(8) : 0;
    for (int i = 0; i < pre; i++)
      row_bits.push_back((i == pre - 1) ? ~sync_cfg[31] : 1'($urandom_range(1)));
    if (with_sync) push_bits(sync_cfg, 32);
    else push_bits(sync_cfg >> 1, 31);
    frame_start = row_bits.size();
    if (!with_sync) return;
    push_bits({24'd0, len}, 8);
    crc = crc16_step(crc_init_cfg, len, poly_cfg);
    for (int n = 0; n < len; n++) begin
      plain = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hff : 8'($urandom);
      crc = crc16_step(crc, plain, poly_cfg);
      push_bits({24'd0, whiten_cfg ? plain ^ pn9_table[n] : plain}, 8);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    push_bits({16'd0, crc}, 16);
  endfunction

  task automatic send_symbol(input logic kind, input logic bitv);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, bitv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    deframe_symbol(kind, bitv);
  endtask

  task automatic send_row(input int keep, input int tail);
    for (int i = 0; i < keep; i++) begin
      send_symbol(1'b0, row_bits[i]);
      sent_items++;
    end
    repeat (tail) begin
      send_symbol(1'b0, 1'($urandom_range(1)));
      sent_items++;
    end
    send_symbol(1'b1, 1'($urandom_range(1)));
    sent_items++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [31:0] sw, input logic [15:0] poly,
                            input logic [15:0] init, input logic wen);
    cfg_addr_e   addrs [4];
    logic [31:0] vals [4];
    addrs = '{CFG_SYNC_WORD, CFG_CRC_POLY, CFG_CRC_INIT, CFG_WHITEN_EN};
    vals = '{sw, {16'd0, poly}, {16'd0, init}, {31'd0, wen}};
    for (int a = 0; a < 4; a++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= addrs[a];
      cfg_data_i <= vals[a];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sync_cfg = sw;
    poly_cfg = poly;
    crc_init_cfg = init;
    whiten_cfg = wen;
  endtask

  // mostly well-formed frames, some cut short by a row end, some noise rows
  task automatic random_rows(input int quota);
    int unsigned start;
    int          r;
    int          len;
    start = sent_items;
    while (sent_items - start < quota) begin
      r = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      if (r < 85) begin
        build_frame(1'b1, 8'(len), FILL_RANDOM, $urandom_range(9) == 0);
        if (r < 70) send_row(row_bits.size(), $urandom_range(4));
        else send_row(frame_start + $urandom_range(row_bits.size() - frame_start - 1), 0);
      end else begin
        row_bits.delete();
        repeat ($urandom_range(40)) row_bits.push_back(1'($urandom_range(1)));
        send_row(row_bits.size(), 0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: transaction with nothing expected: tuser %b tdata %h tlast %b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        compare_field("kind_res", {7'd0, head_result.kind_res}, {7'd0, m_axis_tuser});
        compare_field("data_byte", head_result.data_byte, m_axis_tdata[7:0]);
        compare_field("byte_index", head_result.byte_index, m_axis_tdata[15:8]);
        compare_field("frame_length", head_result.frame_length, m_axis_tdata[23:16]);
        compare_field("status", {6'd0, head_result.status}, {6'd0, m_axis_tdata[25:24]});
        compare_field("tdata pad", 8'd0, {2'd0, m_axis_tdata[31:26]});
        compare_field("last", {7'd0, head_result.last}, {7'd0, m_axis_tlast});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("whitened_packet_deframer_crc16_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    frame_row_t row;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      typed_valid = row.typed;
      typed_status = row.want;
      build_frame(row.with_sync, row.len, row.fill, row.bad_crc);
      if (row.cut < 0) send_row(row_bits.size(), row.with_sync ? $urandom_range(4) : 0);
      else send_row(frame_start + row.cut, 0);
      typed_valid = 1'b0;
    end

    for (int b = 0; b < 6; b++) begin
      settle();
      case (b)
        0: write_regs(32'hd391_d391, 16'h8005, 16'hffff, 1'b1);
        1: write_regs(32'h0000_0000, 16'h1021, 16'h0000, 1'b0);
        2: write_regs(32'hffff_ffff, 16'hffff, 16'hffff, 1'b1);
        3: write_regs($urandom, 16'h0000, 16'h0000, 1'b0);
        4: write_regs($urandom, 16'($urandom), 16'($urandom), 1'($urandom));
        default: write_regs(32'hd391_d391, 16'h8005, 16'hffff, 1'b1);
      endcase
      case (b % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 65;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 65;
        end
        default: begin
          gap_pct = 11;
          stall_pct = 11;
        end
      endcase
      if (b == 0) hold_req = hold_req + 1;
      random_rows(90);
    end

    settle();
    if (errors == 0) begin
      $display("whitened_packet_deframer_crc16_unit_tb OK");
    end else begin
      $display("whitened_packet_deframer_crc16_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
